// File: hdl/elastic_ball_collision_core_macros.svh
// ------------------------------------------------------------------------
// Assertion macros for the elastic ball collision core
// Shared implication forms used by the port checker.
// ------------------------------------------------------------------------
`ifndef ELASTIC_BALL_COLLISION_CORE_MACROS_SVH
`define ELASTIC_BALL_COLLISION_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define EBC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define EBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/ebc_pkg.sv
// ------------------------------------------------------------------------
// Elastic ball collision package
// Shared widths, constants and the classified word passed front to back.
// ------------------------------------------------------------------------
package ebc_pkg;

  localparam int MaxBalls   = 16;
  localparam int InWidth    = 200;
  localparam int OutWidth   = 64;
  localparam logic [15:0] BallSizeReset = 16'd4096;
  localparam int QuoWidth   = 17;  // quotient bits, larger results saturate
  localparam int FifoDepth  = 4;
  localparam int FifoAw     = 2;

  // classified pair, centre offsets already narrowed for the hit path
  typedef struct packed {
    logic               hit;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [31:0]        d2;
    logic signed [16:0] dvx;
    logic signed [16:0] dvy;
    logic signed [15:0] vax;
    logic signed [15:0] vay;
    logic signed [15:0] vbx;
    logic signed [15:0] vby;
    logic [15:0]        ma;
    logic [15:0]        mb;
  } cls_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// File: hdl/ebc_front.sv
// ------------------------------------------------------------------------
// Collision front end
// Accepts ball pairs, runs overlap and approach tests, updates contacts.
// ------------------------------------------------------------------------
module ebc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_wr_en_i,
  input  logic [15:0]                   cfg_wr_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ebc_pkg::InWidth-1:0]   in_data_i,
  input  ebc_pkg::fifo_stat_t           fifo_stat_i,
  output logic                          push_o,
  output ebc_pkg::cls_t                 push_data_o
);

  logic [15:0] bs_q;
  logic        vld1_q, vld2_q, vld3_q;
  logic        en;

  logic [3:0]         s1_ida_q, s1_idb_q;
  logic signed [24:0] s1_dx_q, s1_dy_q;
  logic signed [15:0] s1_vax_q, s1_vay_q, s1_vbx_q, s1_vby_q;
  logic [15:0]        s1_ma_q, s1_mb_q;

  logic [3:0]         s2_ida_q, s2_idb_q;
  logic signed [24:0] s2_dx_q, s2_dy_q;
  logic signed [49:0] s2_dxx_q, s2_dyy_q;
  logic signed [40:0] s2_pa_q, s2_pb_q;
  logic signed [16:0] s2_dvx_q, s2_dvy_q;
  logic [31:0]        s2_size2_q;
  logic signed [15:0] s2_vax_q, s2_vay_q, s2_vbx_q, s2_vby_q;
  logic [15:0]        s2_ma_q, s2_mb_q;

  ebc_pkg::cls_t s3_d, s3_q;
  logic [50:0]        d2sum;
  logic signed [41:0] appr;

  logic [ebc_pkg::MaxBalls-1:0][ebc_pkg::MaxBalls-1:0] contact_q;

  assign en         = !vld3_q || !fifo_stat_i.full;
  assign in_ready_o = en;
  assign push_o      = vld3_q && !fifo_stat_i.full;
  assign push_data_o = s3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bs_q <= ebc_pkg::BallSizeReset;
    end else if (cfg_wr_en_i) begin
      bs_q <= cfg_wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else if (en) begin
      vld1_q <= in_valid_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  // stage 1: centre offsets, zero mass counts as one
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_ida_q <= in_data_i[3:0];
      s1_idb_q <= in_data_i[7:4];
      s1_dx_q  <= {in_data_i[31], in_data_i[31:8]} - {in_data_i[79], in_data_i[79:56]};
      s1_dy_q  <= {in_data_i[55], in_data_i[55:32]} - {in_data_i[103], in_data_i[103:80]};
      s1_vax_q <= in_data_i[119:104];
      s1_vay_q <= in_data_i[135:120];
      s1_vbx_q <= in_data_i[151:136];
      s1_vby_q <= in_data_i[167:152];
      s1_ma_q  <= (in_data_i[183:168] == 16'd0) ? 16'd1 : in_data_i[183:168];
      s1_mb_q  <= (in_data_i[199:184] == 16'd0) ? 16'd1 : in_data_i[199:184];
    end
  end

  // stage 2: squares and approach products
  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_ida_q   <= s1_ida_q;
      s2_idb_q   <= s1_idb_q;
      s2_dx_q    <= s1_dx_q;
      s2_dy_q    <= s1_dy_q;
      s2_dxx_q   <= 50'(s1_dx_q) * 50'(s1_dx_q);
      s2_dyy_q   <= 50'(s1_dy_q) * 50'(s1_dy_q);
      s2_pa_q    <= 41'(s1_dx_q) * 41'(s1_vax_q);
      s2_pb_q    <= 41'(s1_dy_q) * 41'(s1_vay_q);
      s2_dvx_q   <= 17'(s1_vax_q) - 17'(s1_vbx_q);
      s2_dvy_q   <= 17'(s1_vay_q) - 17'(s1_vby_q);
      s2_size2_q <= 32'(bs_q) * 32'(bs_q);
      s2_vax_q   <= s1_vax_q;
      s2_vay_q   <= s1_vay_q;
      s2_vbx_q   <= s1_vbx_q;
      s2_vby_q   <= s1_vby_q;
      s2_ma_q    <= s1_ma_q;
      s2_mb_q    <= s1_mb_q;
    end
  end

  // stage 3: classify; on a hit the offsets fit 17 bits and d2 fits 32
  always_comb begin
    d2sum     = {1'b0, s2_dxx_q} + {1'b0, s2_dyy_q};
    appr      = 42'(s2_pa_q) + 42'(s2_pb_q);
    s3_d.hit  = (d2sum < 51'(s2_size2_q)) && appr[41];
    s3_d.dx   = s2_dx_q[16:0];
    s3_d.dy   = s2_dy_q[16:0];
    s3_d.d2   = d2sum[31:0];
    s3_d.dvx  = s2_dvx_q;
    s3_d.dvy  = s2_dvy_q;
    s3_d.vax  = s2_vax_q;
    s3_d.vay  = s2_vay_q;
    s3_d.vbx  = s2_vbx_q;
    s3_d.vby  = s2_vby_q;
    s3_d.ma   = s2_ma_q;
    s3_d.mb   = s2_mb_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_q <= s3_d;
    end
  end

  // record contact in both rows as the pair is classified
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contact_q <= '0;
    end else if (en && vld2_q) begin
      if (32'(s2_ida_q) < ebc_pkg::MaxBalls && 32'(s2_idb_q) < ebc_pkg::MaxBalls) begin
        contact_q[s2_ida_q][s2_idb_q] <= s3_d.hit;
        contact_q[s2_idb_q][s2_ida_q] <= s3_d.hit;
      end
    end
  end

endmodule

// File: hdl/ebc_fifo.sv
// ------------------------------------------------------------------------
// Collision word queue
// Short queue between classification and impulse resolution.
// ------------------------------------------------------------------------
module ebc_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ebc_pkg::cls_t       push_data_i,
  input  logic                pop_i,
  output ebc_pkg::cls_t       pop_data_o,
  output ebc_pkg::fifo_stat_t stat_o
);

  ebc_pkg::cls_t mem_q [ebc_pkg::FifoDepth];
  logic [ebc_pkg::FifoAw:0] wr_q, rd_q;

  assign stat_o.empty = (wr_q == rd_q);
  assign stat_o.full  = (wr_q[ebc_pkg::FifoAw] != rd_q[ebc_pkg::FifoAw]) &&
                        (wr_q[ebc_pkg::FifoAw-1:0] == rd_q[ebc_pkg::FifoAw-1:0]);
  assign pop_data_o   = mem_q[rd_q[ebc_pkg::FifoAw-1:0]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q[ebc_pkg::FifoAw-1:0]] <= push_data_i;
    end
  end

endmodule

// File: hdl/ebc_back.sv
// ------------------------------------------------------------------------
// Collision back end
// Impulse products, pipelined restoring divide, saturation and output.
// ------------------------------------------------------------------------
module ebc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ebc_pkg::fifo_stat_t           fifo_stat_i,
  input  ebc_pkg::cls_t                 pop_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_hit_o,
  output logic [ebc_pkg::OutWidth-1:0]  out_data_o
);

  localparam int Qw = ebc_pkg::QuoWidth;

  typedef struct packed {
    logic               hit;
    logic [3:0][15:0]   vel;  // A x, A y, B x, B y
  } pass_t;

  typedef struct packed {
    pass_t              p;
    logic [3:0]         neg;
    logic               ovf3, ovf2, ovf1, ovf0;
    logic [49:0]        dn;
    logic [3:0][66:0]   rem;
    logic [3:0][Qw-1:0] quo;
  } div_t;

  logic en;
  logic [6:0]  bv_q;
  logic [Qw:0] dv_vld_q;
  logic        out_vld_q;

  pass_t p1_q, p2_q, p3_q, p4_q, p5_q, p6_q, p7_q;
  logic signed [33:0] b1_px_q, b1_py_q;
  logic signed [16:0] b1_dx_q, b1_dy_q, b2_dx_q, b2_dy_q;
  logic [16:0] b1_msum_q, b1_m2a_q, b1_m2b_q, b2_m2a_q, b2_m2b_q, b3_m2a_q, b3_m2b_q;
  logic [16:0] b4_m2a_q, b4_m2b_q;
  logic [31:0] b1_d2_q;
  logic signed [34:0] b2_dot_q;
  logic [48:0] b2_den_q, b3_den_q, b4_den_q, b5_den_q, b6_den_q;
  logic signed [51:0] b3_qx_q, b3_qy_q;
  logic [50:0] b4_ax_q, b4_ay_q;
  logic b4_nx_q, b4_ny_q, b5_nx_q, b5_ny_q, b6_nx_q, b6_ny_q, b7_nx_q, b7_ny_q;
  logic [3:0][42:0] b5_lo_q;
  logic [3:0][41:0] b5_hi_q;
  logic [3:0][67:0] b6_num_q;
  logic [3:0][69:0] b7_np_q;
  logic [49:0] b7_dn_q;

  div_t dv_q [Qw+1];
  div_t d0_d;
  logic [3:0] d0_ovf;

  logic [3:0][50:0] mag_sel;
  logic [3:0][16:0] mul_sel;

  logic [3:0][15:0] res_d;
  logic [3:0][15:0] res_q;
  logic             hit_q;

  assign en          = !out_vld_q || out_ready_i;
  assign pop_o       = en && !fifo_stat_i.empty;
  assign out_valid_o = out_vld_q;
  assign out_hit_o   = hit_q;
  assign out_data_o  = {res_q[3], res_q[2], res_q[1], res_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q      <= '0;
      dv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      bv_q      <= {bv_q[5:0], !fifo_stat_i.empty};
      dv_vld_q  <= {dv_vld_q[Qw-1:0], bv_q[6]};
      out_vld_q <= dv_vld_q[Qw];
    end
  end

  // B1 to B3: relative normal speed times offset, shared denominator
  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q.hit  <= pop_data_i.hit;
      p1_q.vel  <= {pop_data_i.vby, pop_data_i.vbx, pop_data_i.vay, pop_data_i.vax};
      b1_px_q   <= 34'(pop_data_i.dvx) * 34'(pop_data_i.dx);
      b1_py_q   <= 34'(pop_data_i.dvy) * 34'(pop_data_i.dy);
      b1_dx_q   <= pop_data_i.dx;
      b1_dy_q   <= pop_data_i.dy;
      b1_msum_q <= 17'(pop_data_i.ma) + 17'(pop_data_i.mb);
      b1_m2a_q  <= {pop_data_i.ma, 1'b0};
      b1_m2b_q  <= {pop_data_i.mb, 1'b0};
      b1_d2_q   <= pop_data_i.d2;

      p2_q     <= p1_q;
      b2_dot_q <= 35'(b1_px_q) + 35'(b1_py_q);
      b2_den_q <= 49'(b1_msum_q) * 49'(b1_d2_q);
      b2_dx_q  <= b1_dx_q;
      b2_dy_q  <= b1_dy_q;
      b2_m2a_q <= b1_m2a_q;
      b2_m2b_q <= b1_m2b_q;

      p3_q     <= p2_q;
      b3_qx_q  <= 52'(b2_dot_q) * 52'(b2_dx_q);
      b3_qy_q  <= 52'(b2_dot_q) * 52'(b2_dy_q);
      b3_den_q <= b2_den_q;
      b3_m2a_q <= b2_m2a_q;
      b3_m2b_q <= b2_m2b_q;

      // B4: magnitudes, sign kept aside
      p4_q     <= p3_q;
      b4_nx_q  <= b3_qx_q[51];
      b4_ny_q  <= b3_qy_q[51];
      b4_ax_q  <= b3_qx_q[51] ? 51'(-b3_qx_q) : b3_qx_q[50:0];
      b4_ay_q  <= b3_qy_q[51] ? 51'(-b3_qy_q) : b3_qy_q[50:0];
      b4_den_q <= b3_den_q;
      b4_m2a_q <= b3_m2a_q;
      b4_m2b_q <= b3_m2b_q;
    end
  end

  always_comb begin
    mag_sel[0] = b4_ax_q;  mul_sel[0] = b4_m2b_q;
    mag_sel[1] = b4_ay_q;  mul_sel[1] = b4_m2b_q;
    mag_sel[2] = b4_ax_q;  mul_sel[2] = b4_m2a_q;
    mag_sel[3] = b4_ay_q;  mul_sel[3] = b4_m2a_q;
  end

  // B5 to B7: numerators in two partial products, then rounding offset
  always_ff @(posedge clk_i) begin
    if (en) begin
      p5_q     <= p4_q;
      b5_nx_q  <= b4_nx_q;
      b5_ny_q  <= b4_ny_q;
      b5_den_q <= b4_den_q;
      for (int l = 0; l < 4; l++) begin
        b5_lo_q[l] <= 43'(mag_sel[l][25:0]) * 43'(mul_sel[l]);
        b5_hi_q[l] <= 42'(mag_sel[l][50:26]) * 42'(mul_sel[l]);
      end

      p6_q     <= p5_q;
      b6_nx_q  <= b5_nx_q;
      b6_ny_q  <= b5_ny_q;
      b6_den_q <= b5_den_q;
      for (int l = 0; l < 4; l++) begin
        b6_num_q[l] <= (68'(b5_hi_q[l]) << 26) + 68'(b5_lo_q[l]);
      end

      // round half away: floor((2n + d) / 2d)
      p7_q    <= p6_q;
      b7_nx_q <= b6_nx_q;
      b7_ny_q <= b6_ny_q;
      b7_dn_q <= {b6_den_q, 1'b0};
      for (int l = 0; l < 4; l++) begin
        b7_np_q[l] <= {b6_num_q[l], 1'b0} + 70'(b6_den_q);
      end
    end
  end

  // divider head: catch quotients too large for the quotient width
  always_comb begin
    d0_d.p   = p7_q;
    d0_d.neg = {b7_ny_q, b7_nx_q, b7_ny_q, b7_nx_q};
    d0_d.dn  = b7_dn_q;
    d0_d.quo = '0;
    for (int l = 0; l < 4; l++) begin
      d0_ovf[l]   = b7_np_q[l] >= (70'(b7_dn_q) << Qw);
      d0_d.rem[l] = b7_np_q[l][66:0];
    end
    {d0_d.ovf3, d0_d.ovf2, d0_d.ovf1, d0_d.ovf0} = d0_ovf;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_q[0] <= d0_d;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar g = 0; g < Qw; g++) begin : g_div
    div_t        st_d;
    logic [67:0] trial [4];

    always_comb begin
      st_d = dv_q[g];
      for (int l = 0; l < 4; l++) begin
        trial[l] = {1'b0, dv_q[g].rem[l]} - (68'(dv_q[g].dn) << (Qw - 1 - g));
        if (!trial[l][67]) begin
          st_d.rem[l] = trial[l][66:0];
        end
        st_d.quo[l] = {dv_q[g].quo[l][Qw-2:0], !trial[l][67]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[g+1] <= st_d;
      end
    end
  end

  // apply signed impulse and saturate; miss passes velocities through
  always_comb begin
    logic [3:0]         ovf;
    logic [Qw-1:0]      q;
    logic signed [Qw:0] val;
    logic signed [Qw+1:0] sum;
    ovf = {dv_q[Qw].ovf3, dv_q[Qw].ovf2, dv_q[Qw].ovf1, dv_q[Qw].ovf0};
    for (int l = 0; l < 4; l++) begin
      q   = ovf[l] ? '1 : dv_q[Qw].quo[l];
      val = dv_q[Qw].neg[l] ? -$signed({1'b0, q}) : $signed({1'b0, q});
      if (l < 2) begin
        sum = $signed((Qw+2)'($signed(dv_q[Qw].p.vel[l]))) - (Qw+2)'(val);
      end else begin
        sum = $signed((Qw+2)'($signed(dv_q[Qw].p.vel[l]))) + (Qw+2)'(val);
      end
      if (!dv_q[Qw].p.hit) begin
        res_d[l] = dv_q[Qw].p.vel[l];
      end else if (sum > $signed((Qw+2)'(32767))) begin
        res_d[l] = 16'h7fff;
      end else if (sum < $signed(-(Qw+2)'(32768))) begin
        res_d[l] = 16'h8000;
      end else begin
        res_d[l] = sum[15:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      hit_q <= dv_q[Qw].p.hit;
    end
  end

endmodule

// File: hdl/elastic_ball_collision_core.sv
// ------------------------------------------------------------------------
// Elastic ball collision core
// Resolves 2-D elastic collisions of equal-size ball pairs.
// ------------------------------------------------------------------------
// Takes one ball pair per clock while s_axis_tready is high and returns one
// result per pair in order. Pairs pass through the classification stages,
// the queue and the impulse pipeline, whose restoring divider resolves one
// quotient bit per stage. The four-entry queue lets the front keep taking
// pairs while the output is held, until the queue fills. The contact
// matrix is cleared by reset.
module elastic_ball_collision_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_wr_en_i,
  input  logic [15:0]   cfg_wr_data_i,    // ball_size
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // first_id, second_id, first_pos_x, first_pos_y, second_pos_x, second_pos_y,
  // first_vel_x, first_vel_y, second_vel_x, second_vel_y, first_mass, second_mass
  input  logic [199:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // new_first_vel_x, new_first_vel_y, new_second_vel_x, new_second_vel_y
  output logic [63:0]   m_axis_tdata,
  output logic          m_axis_tuser      // hit
);

  ebc_pkg::fifo_stat_t fifo_stat;
  ebc_pkg::cls_t       push_data, pop_data;
  logic                push, pop;

  ebc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_data_i     (s_axis_tdata),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  ebc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (fifo_stat)
  );

  ebc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_stat_i (fifo_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (m_axis_tuser),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// File: hdl/ebc_checker.sv
// ------------------------------------------------------------------------
// Elastic ball collision port checker
// Watches the top-level ports and flags handshake and reset slips.
// ------------------------------------------------------------------------
`include "elastic_ball_collision_core_macros.svh"

module ebc_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [63:0]   m_axis_tdata,
  input logic          m_axis_tuser
);

  `EBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")
  `EBC_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result word changed")
  `EBC_ASSERT_NOW(a_rst_idle, clk_i, rst_ni, $rose(rst_ni), !m_axis_tvalid, "result word out of reset")
  `EBC_ASSERT_NOW(a_rst_ready, clk_i, rst_ni, $rose(rst_ni), s_axis_tready, "input not ready out of reset")

endmodule

bind elastic_ball_collision_core ebc_checker u_ebc_checker (.*);
